// File: hdl/voxel_ray_cast_face_distance_defines.svh
// Assertion macros used by the checker file.
`ifndef VOXEL_RAY_CAST_FACE_DISTANCE_DEFINES_SVH
`define VOXEL_RAY_CAST_FACE_DISTANCE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VRC_ASSERT_NOW(label, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VRC_ASSERT_NEXT(label, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hdl/vrc_pkg.sv
package vrc_pkg;
	localparam int MAP_AXIS_BITS = 5;
	localparam int FRAC_BITS = 16;
	localparam int STEP_BITS = 8;
	localparam int TILE_BITS = 8;
	localparam int LEN_FRAC_BITS = 8;

	localparam int POS_W = MAP_AXIS_BITS + FRAC_BITS;
	localparam int STEP_W = STEP_BITS + 2;
	localparam int ACC_W = FRAC_BITS + 1;
	localparam int ADDR_W = 3 * MAP_AXIS_BITS;
	localparam int LEN_W = 16;
	localparam int TICK_W = 16;
	localparam int DIST_W = 16;
	localparam int PROD_W = LEN_W + TICK_W;
	localparam int FACE_W = 3;

	localparam logic [FACE_W-1:0] FACE_NONE = 3'd0;

	// Byte address of the walk limit register.
	localparam logic [1:0] REG_WALK_LIMIT = 2'd0;
endpackage

// File: hdl/vrc_ram.sv
module vrc_ram #(
	parameter int AW = 15,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// File: hdl/vrc_div.sv
module vrc_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [vrc_pkg::PROD_W-1:0]   dividend,
	input  logic [vrc_pkg::TICK_W-1:0]   divisor,
	output logic                         done,
	output logic [vrc_pkg::DIST_W-1:0]   quotient
);
	localparam int CNT_W = $clog2(vrc_pkg::PROD_W + 1);

	logic [vrc_pkg::PROD_W-1:0] work_q;
	logic [vrc_pkg::TICK_W-1:0] dsr_q;
	logic [vrc_pkg::TICK_W-1:0] rem_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic [vrc_pkg::TICK_W:0]   rem_sh;
	logic                       take;

	// Restoring division, one quotient bit per cycle; quotient bits shift into work_q.
	always_comb begin
		rem_sh = {rem_q, work_q[vrc_pkg::PROD_W-1]};
		take = rem_sh >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(vrc_pkg::PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? vrc_pkg::TICK_W'(rem_sh - {1'b0, dsr_q})
				: rem_sh[vrc_pkg::TICK_W-1:0];
			work_q <= {work_q[vrc_pkg::PROD_W-2:0], take};
		end
	end

	assign quotient = work_q[vrc_pkg::DIST_W-1:0];
endmodule

// File: hdl/voxel_ray_cast_face_distance.sv
// Channel   Direction  Handshake                 Content
// input     in         in_valid / in_ready       action, position, step, length, tile
// output    out        out_valid / out_ready     hit, voxel, previous voxel, tile, face, distance
// config    in         psel / penable / pwrite   walk limit at byte address 0
//
// After reset a clearing pass zeroes all 32768 voxels of the store, one voxel a cycle;
// no input transfer is taken until it ends, configuration writes are taken.
// A write item goes from idle straight to the done state. In a cast each tick first
// advances all accumulators, then visits each axis in turn; an axis that steps also
// reads the voxel store and tests the voxel, and on a hit the multiply and the bit-serial
// distance division follow; ticks is min(length_q8 + 1, walk limit).
// The voxel store is single-port. A finished result sits in the output
// register, so the next input transfer is taken while it waits on out_ready.
module voxel_ray_cast_face_distance (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              action,
	input  logic [vrc_pkg::POS_W-1:0]         pos_x,
	input  logic [vrc_pkg::POS_W-1:0]         pos_y,
	input  logic [vrc_pkg::POS_W-1:0]         pos_z,
	input  logic signed [vrc_pkg::STEP_W-1:0] step_x,
	input  logic signed [vrc_pkg::STEP_W-1:0] step_y,
	input  logic signed [vrc_pkg::STEP_W-1:0] step_z,
	input  logic [vrc_pkg::LEN_W-1:0]         length_q8,
	input  logic [vrc_pkg::TILE_BITS-1:0]     tile_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic [vrc_pkg::MAP_AXIS_BITS-1:0] hit_x,
	output logic [vrc_pkg::MAP_AXIS_BITS-1:0] hit_y,
	output logic [vrc_pkg::MAP_AXIS_BITS-1:0] hit_z,
	output logic [vrc_pkg::MAP_AXIS_BITS-1:0] prev_x,
	output logic [vrc_pkg::MAP_AXIS_BITS-1:0] prev_y,
	output logic [vrc_pkg::MAP_AXIS_BITS-1:0] prev_z,
	output logic [vrc_pkg::TILE_BITS-1:0]     hit_tile,
	output logic [vrc_pkg::FACE_W-1:0]        face,
	output logic [vrc_pkg::DIST_W-1:0]        distance_q8,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [1:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	localparam int MB = vrc_pkg::MAP_AXIS_BITS;
	localparam int FB = vrc_pkg::FRAC_BITS;
	localparam int AW = vrc_pkg::ADDR_W;
	localparam int TW = vrc_pkg::TICK_W;
	localparam int LSH_W = vrc_pkg::LEN_W + FB;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_TICK, S_AXIS, S_TEST, S_MUL, S_DIV, S_DONE
	} state_t;

	state_t state_q;

	logic [TW-1:0] walk_limit_q;
	logic [AW-1:0] clr_q;

	logic [MB-1:0]                 ipos_q [3];
	logic [MB-1:0]                 prv_q [3];
	logic [vrc_pkg::ACC_W-1:0]     acc_q [3];
	logic [vrc_pkg::STEP_W-1:0]    mag_q [3];
	logic [2:0]                    neg_q;
	logic [2:0]                    carry_q;
	logic [1:0]                    axis_q;
	logic [vrc_pkg::LEN_W-1:0]     len_q;
	logic [TW-1:0]                 ticks_q;
	logic [TW-1:0]                 i_q;
	logic                          hit_q;
	logic [vrc_pkg::TILE_BITS-1:0] tile_q;
	logic [vrc_pkg::FACE_W-1:0]    face_q;
	logic [vrc_pkg::PROD_W-1:0]    prod_q;
	logic                          div_start_q;

	logic                          ram_we;
	logic [AW-1:0]                 ram_addr;
	logic [vrc_pkg::TILE_BITS-1:0] ram_wdata;
	logic [vrc_pkg::TILE_BITS-1:0] ram_rdata;
	logic                          div_done;
	logic [vrc_pkg::DIST_W-1:0]    div_q;

	logic                          in_fire;
	logic                          out_free;
	logic [MB-1:0]                 in_ipos [3];
	logic [FB-1:0]                 in_frac [3];
	logic [vrc_pkg::STEP_W-1:0]    in_step [3];
	logic [LSH_W-1:0]              len_sh;
	logic [TW-1:0]                 in_ticks;
	logic [vrc_pkg::ACC_W-1:0]     acc_sum [3];
	logic [MB-1:0]                 nxt_pos [3];
	logic [MB-1:0]                 rd_pos [3];
	logic                          last_axis;

	assign pready = 1'b1;
	assign prdata = (paddr == vrc_pkg::REG_WALK_LIMIT) ? {{(32-TW){1'b0}}, walk_limit_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_limit_q <= TW'(1024);
		end else if (psel && penable && pwrite) begin
			walk_limit_q <= pwdata[TW-1:0];
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign in_fire = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	always_comb begin
		in_ipos[0] = pos_x[FB +: MB];
		in_ipos[1] = pos_y[FB +: MB];
		in_ipos[2] = pos_z[FB +: MB];
		in_frac[0] = pos_x[FB-1:0];
		in_frac[1] = pos_y[FB-1:0];
		in_frac[2] = pos_z[FB-1:0];
		in_step[0] = step_x;
		in_step[1] = step_y;
		in_step[2] = step_z;
		// Walk length is the shifted length plus one, capped at the walk limit.
		len_sh = {length_q8, {FB{1'b0}}} >> (vrc_pkg::STEP_BITS + vrc_pkg::LEN_FRAC_BITS);
		if (len_sh >= LSH_W'(walk_limit_q)) begin
			in_ticks = walk_limit_q;
		end else begin
			in_ticks = TW'(len_sh + 1'b1);
		end
		for (int a = 0; a < 3; a++) begin
			acc_sum[a] = acc_q[a] + vrc_pkg::ACC_W'(mag_q[a]);
			nxt_pos[a] = neg_q[a] ? ipos_q[a] - 1'b1 : ipos_q[a] + 1'b1;
			rd_pos[a] = ipos_q[a];
		end
		// The axis that steps now is read at its new coordinate.
		rd_pos[axis_q] = nxt_pos[axis_q];
		last_axis = (axis_q == 2'd2);
	end

	always_comb begin
		ram_we = 1'b0;
		ram_wdata = tile_value;
		ram_addr = {rd_pos[2], rd_pos[1], rd_pos[0]};
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_wdata = '0;
				ram_addr = clr_q;
			end
			S_IDLE: begin
				ram_we = in_fire && !action;
				ram_addr = {in_ipos[2], in_ipos[1], in_ipos[0]};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	vrc_ram #(.AW(AW), .DW(vrc_pkg::TILE_BITS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	vrc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (prod_q),
		.divisor  (ticks_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// Main sequencer: per tick, all accumulators advance together, then the carrying axes
	// step one at a time in x, y, z order, each followed by a store read and a test.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			out_valid <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= (state_q == S_MUL);
			// In the done state the output register is reloaded in the same cycle instead.
			if (out_valid && out_ready && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {AW{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						state_q <= action ? S_TICK : S_DONE;
					end
				end
				S_TICK: begin
					state_q <= (i_q == ticks_q) ? S_DONE : S_AXIS;
				end
				S_AXIS: begin
					if (carry_q[axis_q]) begin
						state_q <= S_TEST;
					end else if (last_axis) begin
						state_q <= S_TICK;
					end
				end
				S_TEST: begin
					if (ram_rdata != '0) begin
						state_q <= S_MUL;
					end else begin
						state_q <= last_axis ? S_TICK : S_AXIS;
					end
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Walk data path.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				hit_q <= 1'b0;
				len_q <= length_q8;
				ticks_q <= in_ticks;
				i_q <= '0;
				for (int a = 0; a < 3; a++) begin
					ipos_q[a] <= in_ipos[a];
					prv_q[a] <= in_ipos[a];
					neg_q[a] <= in_step[a][vrc_pkg::STEP_W-1];
					mag_q[a] <= in_step[a][vrc_pkg::STEP_W-1] ? -in_step[a] : in_step[a];
					acc_q[a] <= in_step[a][vrc_pkg::STEP_W-1]
						? (vrc_pkg::ACC_W'(1) << FB) - vrc_pkg::ACC_W'(in_frac[a])
						: vrc_pkg::ACC_W'(in_frac[a]);
				end
			end
			S_TICK: begin
				axis_q <= '0;
				for (int a = 0; a < 3; a++) begin
					carry_q[a] <= acc_sum[a][FB];
					acc_q[a] <= acc_sum[a][FB] ? acc_sum[a] - (vrc_pkg::ACC_W'(1) << FB)
						: acc_sum[a];
				end
			end
			S_AXIS: begin
				if (carry_q[axis_q]) begin
					prv_q[axis_q] <= ipos_q[axis_q];
					ipos_q[axis_q] <= nxt_pos[axis_q];
				end else if (last_axis) begin
					i_q <= i_q + 1'b1;
				end else begin
					axis_q <= axis_q + 1'b1;
				end
			end
			S_TEST: begin
				if (ram_rdata != '0) begin
					hit_q <= 1'b1;
					tile_q <= ram_rdata;
					face_q <= vrc_pkg::FACE_W'({axis_q, neg_q[axis_q]} + 1'b1);
				end else if (last_axis) begin
					i_q <= i_q + 1'b1;
				end else begin
					axis_q <= axis_q + 1'b1;
				end
			end
			S_MUL: begin
				prod_q <= vrc_pkg::PROD_W'(len_q) * vrc_pkg::PROD_W'(i_q);
			end
			default: begin
			end
		endcase
	end

	// Output register; writes and misses report every field as zero.
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			hit <= hit_q;
			hit_x <= hit_q ? ipos_q[0] : '0;
			hit_y <= hit_q ? ipos_q[1] : '0;
			hit_z <= hit_q ? ipos_q[2] : '0;
			prev_x <= hit_q ? prv_q[0] : '0;
			prev_y <= hit_q ? prv_q[1] : '0;
			prev_z <= hit_q ? prv_q[2] : '0;
			hit_tile <= hit_q ? tile_q : '0;
			face <= hit_q ? face_q : vrc_pkg::FACE_NONE;
			distance_q8 <= hit_q ? div_q : '0;
		end
	end
endmodule

// File: hdl/vrc_chk.sv
`include "voxel_ray_cast_face_distance_defines.svh"

module vrc_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              hit,
	input logic [vrc_pkg::TILE_BITS-1:0]     hit_tile,
	input logic [vrc_pkg::FACE_W-1:0]        face,
	input logic [vrc_pkg::DIST_W-1:0]        distance_q8
);
	`VRC_ASSERT_NEXT(a_out_hold, arst_n, out_valid && !out_ready, out_valid)
	`VRC_ASSERT_NEXT(a_out_stable, arst_n, out_valid && !out_ready, $stable(face) && $stable(distance_q8))
	`VRC_ASSERT_NOW(a_miss_zero, arst_n, out_valid && !hit, face == vrc_pkg::FACE_NONE && hit_tile == '0 && distance_q8 == '0)
	`VRC_ASSERT_NOW(a_hit_solid, arst_n, out_valid && hit, hit_tile != '0 && face != vrc_pkg::FACE_NONE)
endmodule

bind voxel_ray_cast_face_distance vrc_chk u_vrc_chk (.*);

// File: dv/voxel_ray_cast_face_distance_tb.sv
module voxel_ray_cast_face_distance_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAP_AXIS_BITS = vrc_pkg::MAP_AXIS_BITS;
	localparam int FRAC_BITS = vrc_pkg::FRAC_BITS;
	localparam int TILE_BITS = vrc_pkg::TILE_BITS;
	localparam int POS_W = vrc_pkg::POS_W;
	localparam int STEP_W = vrc_pkg::STEP_W;
	localparam int LEN_W = vrc_pkg::LEN_W;
	localparam int TICK_W = vrc_pkg::TICK_W;
	localparam int DIST_W = vrc_pkg::DIST_W;
	localparam int FACE_W = vrc_pkg::FACE_W;
	localparam int ADDR_W = vrc_pkg::ADDR_W;

	// Item codes.
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_CAST = 1'b1;

	// Face codes: the direction of the step that entered the solid voxel.
	localparam logic [FACE_W-1:0] FACE_POS_X = 3'd1;
	localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd2;
	localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd3;
	localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd4;
	localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd5;
	localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd6;

	localparam int VOXELS = 1 << ADDR_W;
	localparam int CYCLE_LIMIT = 20000000;
	localparam int LONG_HOLD = 3000;

	typedef struct packed {
		logic                     action;
		logic [POS_W-1:0]         px;
		logic [POS_W-1:0]         py;
		logic [POS_W-1:0]         pz;
		logic signed [STEP_W-1:0] sx;
		logic signed [STEP_W-1:0] sy;
		logic signed [STEP_W-1:0] sz;
		logic [LEN_W-1:0]         len;
		logic [TILE_BITS-1:0]     tile;
	} ray_item_t;

	typedef struct packed {
		logic                     hit;
		logic [MAP_AXIS_BITS-1:0] hx;
		logic [MAP_AXIS_BITS-1:0] hy;
		logic [MAP_AXIS_BITS-1:0] hz;
		logic [MAP_AXIS_BITS-1:0] qx;
		logic [MAP_AXIS_BITS-1:0] qy;
		logic [MAP_AXIS_BITS-1:0] qz;
		logic [TILE_BITS-1:0]     tile;
		logic [FACE_W-1:0]        face;
		logic [DIST_W-1:0]        dq8;
	} ray_result_t;

	typedef struct packed {
		ray_item_t   item;
		logic        typed;
		ray_result_t want;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = 1'b0;
	logic [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [STEP_W-1:0] step_x = '0, step_y = '0, step_z = '0;
	logic [LEN_W-1:0] length_q8 = '0;
	logic [TILE_BITS-1:0] tile_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;
	logic [MAP_AXIS_BITS-1:0] hit_x, hit_y, hit_z, prev_x, prev_y, prev_z;
	logic [TILE_BITS-1:0] hit_tile;
	logic [FACE_W-1:0] face;
	logic [DIST_W-1:0] distance_q8;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	voxel_ray_cast_face_distance uut (.*);

	always #5 clk = ~clk;

	// Shadow copy of the block's state: the tile cube and the tick limit.
	logic [TILE_BITS-1:0] tile_mem [VOXELS];
	int unsigned tick_limit;

	ray_result_t expected_results[$];
	int errors = 0;
	int cycles = 0;
	bit hold_req = 0;
	directed_row_t rows[$];

	function automatic int unsigned voxel_addr(int unsigned x, int unsigned y, int unsigned z);
		return (z << (2 * MAP_AXIS_BITS)) | (y << MAP_AXIS_BITS) | x;
	endfunction

	// Walks the ray the way the block does and returns the result it should report.
	// A write item updates the shadow cube and yields an all-zero result.
	function automatic ray_result_t cast_predict(ray_item_t it);
		ray_result_t r;
		int unsigned pos[3], prv[3], acc[3], mag[3], raw, fr, ticks, i, a, hit_axis;
		bit neg[3];
		bit found;
		logic [FACE_W-1:0] faces[6];
		logic [POS_W-1:0] p[3];
		logic [STEP_W-1:0] s[3];
		faces = '{FACE_POS_X, FACE_NEG_X, FACE_POS_Y, FACE_NEG_Y, FACE_POS_Z, FACE_NEG_Z};
		p = '{it.px, it.py, it.pz};
		s = '{it.sx, it.sy, it.sz};
		r = '0;
		found = 0;
		hit_axis = 0;
		for (a = 0; a < 3; a++) begin
			raw = 32'(s[a]);
			fr = 32'(p[a][FRAC_BITS-1:0]);
			pos[a] = 32'(p[a][POS_W-1:FRAC_BITS]);
			prv[a] = pos[a];
			neg[a] = s[a][STEP_W-1];
			mag[a] = neg[a] ? ((1 << STEP_W) - raw) : raw;
			acc[a] = neg[a] ? ((1 << FRAC_BITS) - fr) : fr;
		end
		if (it.action == ACT_WRITE) begin
			tile_mem[voxel_addr(pos[0], pos[1], pos[2])] = it.tile;
			return r;
		end
		ticks = 32'(it.len) + 1;
		if (ticks > tick_limit)
			ticks = tick_limit;
		for (i = 0; i < ticks; i++) begin
			for (a = 0; a < 3; a++)
				acc[a] += mag[a];
			for (a = 0; a < 3 && !found; a++) begin
				if (acc[a] >= (1 << FRAC_BITS)) begin
					acc[a] -= (1 << FRAC_BITS);
					prv[a] = pos[a];
					pos[a] = (pos[a] + (neg[a] ? (1 << MAP_AXIS_BITS) - 1 : 1))
						% (1 << MAP_AXIS_BITS);
					if (tile_mem[voxel_addr(pos[0], pos[1], pos[2])] != 0) begin
						found = 1;
						hit_axis = a;
					end
				end
			end
			if (found)
				break;
		end
		if (found) begin
			r.hit = 1'b1;
			r.hx = MAP_AXIS_BITS'(pos[0]);
			r.hy = MAP_AXIS_BITS'(pos[1]);
			r.hz = MAP_AXIS_BITS'(pos[2]);
			r.qx = MAP_AXIS_BITS'(prv[0]);
			r.qy = MAP_AXIS_BITS'(prv[1]);
			r.qz = MAP_AXIS_BITS'(prv[2]);
			r.tile = tile_mem[voxel_addr(pos[0], pos[1], pos[2])];
			r.face = faces[2 * hit_axis + neg[hit_axis]];
			r.dq8 = DIST_W'((longint'(it.len) * i) / ticks);
		end
		return r;
	endfunction

	function automatic ray_item_t make_item(logic act, int x, int y, int z, int fx, int fy,
			int fz, int sx, int sy, int sz, int len, int tile);
		ray_item_t it;
		it.action = act;
		it.px = POS_W'((x << FRAC_BITS) | fx);
		it.py = POS_W'((y << FRAC_BITS) | fy);
		it.pz = POS_W'((z << FRAC_BITS) | fz);
		it.sx = STEP_W'(sx);
		it.sy = STEP_W'(sy);
		it.sz = STEP_W'(sz);
		it.len = LEN_W'(len);
		it.tile = TILE_BITS'(tile);
		return it;
	endfunction

	// A random item. Most of them stay inside a small corner of the cube so that writes
	// build up solid voxels there and casts actually run into them.
	function automatic ray_item_t random_item(int write_pct, int len_hi);
		ray_item_t it;
		int lim;
		lim = ($urandom_range(0, 9) == 0) ? 31 : 7;
		it.action = ($urandom_range(0, 99) < write_pct) ? ACT_WRITE : ACT_CAST;
		it.px = POS_W'(($urandom_range(0, lim) << FRAC_BITS) | $urandom_range(0, 65535));
		it.py = POS_W'(($urandom_range(0, lim) << FRAC_BITS) | $urandom_range(0, 65535));
		it.pz = POS_W'(($urandom_range(0, lim) << FRAC_BITS) | $urandom_range(0, 65535));
		it.sx = STEP_W'(int'($urandom_range(0, 512)) - 256);
		it.sy = STEP_W'(int'($urandom_range(0, 512)) - 256);
		it.sz = STEP_W'(int'($urandom_range(0, 512)) - 256);
		if ($urandom_range(0, 99) < 15)
			it.len = LEN_W'($urandom_range(0, 255));
		else
			it.len = LEN_W'($urandom_range(256, len_hi));
		it.tile = ($urandom_range(0, 99) < 15) ? 8'd0 : TILE_BITS'($urandom_range(1, 255));
		return it;
	endfunction

	// Offers one item and returns at the clock edge where its transfer takes place.
	// The expectation is queued at acceptance, so it sees the store and tick limit
	// exactly as the block does.
	task automatic send_item(ray_item_t it, bit typed, ray_result_t want);
		ray_result_t pred;
		action <= it.action;
		pos_x <= it.px;
		pos_y <= it.py;
		pos_z <= it.pz;
		step_x <= it.sx;
		step_y <= it.sy;
		step_z <= it.sz;
		length_q8 <= it.len;
		tile_value <= it.tile;
		in_valid <= 1'b1;
		do
			@(negedge clk);
		while (!in_ready);
		pred = cast_predict(it);
		expected_results.push_back(typed ? want : pred);
		@(posedge clk);
	endtask

	// Leaves the input idle for a gap of length n; with n zero the next item follows at once.
	task automatic input_gap(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 60);
	endfunction

	// Lets the block drain completely before the tick limit changes.
	task automatic drain_and_idle();
		input_gap(1);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// APB-style write followed by a read back of the same register.
	task automatic set_tick_limit(int unsigned value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= vrc_pkg::REG_WALK_LIMIT;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		tick_limit = value & 16'hFFFF;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata[TICK_W-1:0] !== tick_limit[TICK_W-1:0]) begin
			$display("%0t: walk limit read back expected %0d actual %0d", $realtime,
				tick_limit, prdata[TICK_W-1:0]);
			errors++;
		end
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic random_phase(int count, int write_pct, int len_hi, bit stress);
		ray_item_t it;
		ray_result_t none;
		int n;
		none = '0;
		for (n = 0; n < count; n++) begin
			if (stress && n == 60)
				hold_req = 1;
			if (stress && n == 150) begin
				// The sender stops until every outstanding result has been checked.
				input_gap(1);
				while (expected_results.size() != 0)
					@(posedge clk);
			end
			it = random_item(n < 40 ? 85 : write_pct, len_hi);
			send_item(it, 1'b0, none);
			// Right after the long hold starts the sender keeps offering back to back.
			if (stress && n >= 60 && n < 66)
				input_gap(0);
			else
				input_gap(gap_length());
		end
	endtask

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $realtime, name, want, got);
			errors++;
		end
	endfunction

	// Result checking. Outputs and out_ready settle after the rising edge, so the
	// values seen at the falling edge are the ones the next transfer carries.
	always @(negedge clk) begin
		ray_result_t w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result transfer with nothing expected", $realtime);
				errors++;
			end else begin
				w = expected_results.pop_front();
				check_field("hit", w.hit, hit);
				check_field("hit_x", w.hx, hit_x);
				check_field("hit_y", w.hy, hit_y);
				check_field("hit_z", w.hz, hit_z);
				check_field("prev_x", w.qx, prev_x);
				check_field("prev_y", w.qy, prev_y);
				check_field("prev_z", w.qz, prev_z);
				check_field("hit_tile", w.tile, hit_tile);
				check_field("face", w.face, face);
				check_field("distance_q8", w.dq8, distance_q8);
			end
		end
	end

	// Receiver: random stretches of ready and stall, plus one long hold on request.
	initial begin
		int run;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				for (run = 0; run < LONG_HOLD; run++)
					@(posedge clk);
				hold_req = 0;
			end
			if ($urandom_range(0, 99) < 60) begin
				out_ready <= 1'b1;
				run = $urandom_range(1, 40);
			end else begin
				out_ready <= 1'b0;
				run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
			end
			repeat (run - 1) @(posedge clk);
		end
	end

	// Watchdog. The limit leaves ample room for the clearing pass and the longest
	// casts.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		ray_result_t none, write_done;
		int n;
		none = '0;
		write_done = '0;
		for (n = 0; n < VOXELS; n++)
			tile_mem[n] = '0;
		tick_limit = 1024;

		// Directed rows: typed results for writes and for casts that must miss; the other casts use the prediction.
		// Empty store, positions, length and tile at their top: nothing to hit.
		rows.push_back('{make_item(ACT_CAST, 31, 31, 31, 65535, 65535, 65535, 256, 256, 256,
			65535, 255), 1'b1, none});
		// Zero steps on all axes never carry, so the shortest cast misses.
		rows.push_back('{make_item(ACT_CAST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, none});
		rows.push_back('{make_item(ACT_WRITE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 255), 1'b1,
			write_done});
		rows.push_back('{make_item(ACT_WRITE, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1,
			write_done});
		rows.push_back('{make_item(ACT_WRITE, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 170), 1'b1,
			write_done});
		rows.push_back('{make_item(ACT_WRITE, 0, 31, 0, 0, 0, 0, 0, 0, 0, 0, 85), 1'b1,
			write_done});
		rows.push_back('{make_item(ACT_WRITE, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 15), 1'b1,
			write_done});
		rows.push_back('{make_item(ACT_WRITE, 0, 0, 31, 0, 0, 0, 0, 0, 0, 0, 240), 1'b1,
			write_done});
		// Positive x walk into the tile next door.
		rows.push_back('{make_item(ACT_CAST, 0, 0, 0, 0, 0, 0, 256, 0, 0, 65535, 0), 1'b0, none});
		// Negative steps with zero fraction step on the first tick and wrap to 31.
		rows.push_back('{make_item(ACT_CAST, 0, 0, 0, 0, 0, 0, -256, 0, 0, 65535, 0), 1'b0,
			none});
		rows.push_back('{make_item(ACT_CAST, 0, 0, 0, 0, 0, 0, 0, 256, 0, 65535, 0), 1'b0, none});
		rows.push_back('{make_item(ACT_CAST, 0, 0, 0, 0, 0, 0, 0, -256, 0, 65535, 0), 1'b0,
			none});
		rows.push_back('{make_item(ACT_CAST, 0, 0, 0, 0, 0, 0, 0, 0, 256, 65535, 0), 1'b0, none});
		rows.push_back('{make_item(ACT_CAST, 0, 0, 0, 0, 0, 0, 0, 0, -256, 65535, 0), 1'b0,
			none});
		// All three axes carry on the same tick: x goes first.
		rows.push_back('{make_item(ACT_CAST, 0, 0, 0, 65535, 65535, 65535, 256, 256, 256, 10, 0),
			1'b0, none});
		// Steps outside the nominal range.
		rows.push_back('{make_item(ACT_CAST, 0, 0, 0, 100, 0, 0, 511, -512, 0, 600, 0), 1'b0,
			none});
		// A short ray that runs out of ticks before the carry.
		rows.push_back('{make_item(ACT_CAST, 0, 0, 0, 0, 0, 0, 256, 0, 0, 100, 0), 1'b1, none});
		// Tile zero clears a voxel again.
		rows.push_back('{make_item(ACT_WRITE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			write_done});
		rows.push_back('{make_item(ACT_CAST, 0, 0, 0, 0, 0, 0, 256, 0, 0, 65535, 0), 1'b0, none});
		rows.push_back('{make_item(ACT_WRITE, 31, 31, 31, 65535, 65535, 65535, -256, -256, -256,
			65535, 255), 1'b1, write_done});
		rows.push_back('{make_item(ACT_CAST, 31, 31, 30, 65535, 65535, 65535, 1, -1, 256,
			65535, 0), 1'b0, none});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The tick limit is written while the clearing pass still runs.
		set_tick_limit(1024);
		foreach (rows[n]) begin
			send_item(rows[n].item, rows[n].typed, rows[n].want);
			input_gap(gap_length());
		end

		// With no ticks allowed every cast misses.
		drain_and_idle();
		set_tick_limit(0);
		send_item(make_item(ACT_CAST, 0, 0, 0, 0, 0, 0, -256, 0, 0, 65535, 0), 1'b1, none);
		input_gap(0);
		send_item(make_item(ACT_CAST, 0, 0, 0, 0, 0, 0, 256, 256, 256, 0, 0), 1'b1, none);

		drain_and_idle();
		set_tick_limit(1024);
		random_phase(300, 35, 4095, 1'b1);

		drain_and_idle();
		set_tick_limit(65535);
		random_phase(50, 30, 2000, 1'b0);
		send_item(make_item(ACT_CAST, 0, 0, 0, 0, 0, 0, 256, 255, -255, 65535, 0), 1'b0, none);

		drain_and_idle();
		set_tick_limit(1);
		random_phase(60, 30, 65535, 1'b0);

		drain_and_idle();
		set_tick_limit(300);
		random_phase(90, 30, 4095, 1'b0);

		input_gap(1);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
